// ----- rtl/fdcr_pkg.sv -----
package fdcr_pkg;

  localparam int TRACK_BYTES_DEF = 6250;
  localparam int DELAY_W         = 16;

  localparam logic [DELAY_W-1:0] SEEK_DELAY_RST   = 16'd6000;
  localparam logic [DELAY_W-1:0] SECTOR_DELAY_RST = 16'd12;
  localparam logic [DELAY_W-1:0] TRACK_DELAY_RST  = 16'd10000;

  // polls until DRQ is shown after a transfer command
  localparam logic [2:0] DRQ_POLLS = 3'd5;

  // command byte, upper nibble
  localparam logic [3:0] OP_RESTORE      = 4'h0;
  localparam logic [3:0] OP_SEEK         = 4'h1;
  localparam logic [3:0] OP_READ_SECTOR  = 4'h8;
  localparam logic [3:0] OP_WRITE_SECTOR = 4'ha;
  localparam logic [3:0] OP_WRITE_TRACK  = 4'hf;

  // status and extended read bits
  localparam logic [7:0] ST_BUSY      = 8'h01;
  localparam logic [7:0] ST_TRK0      = 8'h04;
  localparam logic [7:0] ST_WPROT     = 8'h40;
  localparam logic [7:0] ST_NOT_READY = 8'h80;
  localparam logic [7:0] EXT_INDEX    = 8'h20;
  localparam logic [7:0] EXT_DCHG     = 8'h40;

  typedef enum logic [2:0] {
    CMD_PORT_WR  = 3'd0,
    CMD_PORT_RD  = 3'd1,
    CMD_DRQ_POLL = 3'd2,
    CMD_DMA_WR   = 3'd3,
    CMD_DMA_RD   = 3'd4,
    CMD_DMA_DONE = 3'd5,
    CMD_TICK     = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    PORT_CMD    = 3'd0,
    PORT_TRACK  = 3'd1,
    PORT_SECTOR = 3'd2,
    PORT_DATA   = 3'd3,
    PORT_EXT    = 3'd4
  } port_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SEEK   = 2'd1,
    KIND_SECTOR = 2'd2,
    KIND_TRACK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_SEEK_DELAY   = 2'd0,
    CFG_SECTOR_DELAY = 2'd1,
    CFG_TRACK_DELAY  = 2'd2
  } cfg_idx_t;

  // declared from the top bit down: rdata ends up in the lowest bits
  typedef struct packed {
    logic [7:0] format_track;
    logic       format_start;
    logic [7:0] seek_target;
    logic       seek_start;
    logic       drive_select;
    logic       irq_pending;
    logic       irq_pulse;
    logic       drq_out;
    logic [7:0] rdata;
  } res_t;

endpackage

// ----- rtl/floppy_disk_controller_registers_unit.sv -----
// Channel | Dir | Signals                        | Item
// --------+-----+--------------------------------+---------------------------------
// in_     | in  | in_tvalid/tready/tdata/tuser   | one bus, DMA or tick operation
// out_    | out | out_tvalid/tready/tdata        | one result per input item
// cfg_    | in  | cfg_valid/ready/index/wdata    | write of one delay register
//
// Throughput: one item per cycle unless out_tready holds the output; a result
// passes the result stage, then the output register, before out_tvalid rises.
// Register state updates in the accept cycle; the track buffer RAM read of a DMA
// read is registered at the accepting edge and joins the result in the result stage.
// Reset: synchronous rst_n; no clearing pass. A fill mark tracks how far the buffer
// has been touched; untouched bytes read as zero (a DMA read there writes a zero).
// Stalls: out_tready low holds the output; in_tready drops only when both the
// result stage and the output register are full and out_tready is low.
// cfg_ready is always high.
module floppy_disk_controller_registers_unit #(
  parameter int TRACK_BYTES = fdcr_pkg::TRACK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] wdata, [8] drive_loaded, [9] write_protected, [10] at_track0,
  // [11] disk_changed, [12] index_hole, [13] disk_present, [15:14] zero
  input  logic [15:0] in_tdata,
  // [2:0] cmd, [5:3] port_sel
  input  logic [5:0]  in_tuser,
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] rdata, [8] drq_out, [9] irq_pulse, [10] irq_pending,
  // [11] drive_select, [12] seek_start, [20:13] seek_target,
  // [21] format_start, [29:22] format_track, [31:30] zero
  output logic [31:0] out_tdata,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = $clog2(TRACK_BYTES);
  localparam int PW = $clog2(TRACK_BYTES + 1);
  localparam logic [PW-1:0] POS_END = PW'(TRACK_BYTES);

  // ---------------- configuration ----------------
  logic [fdcr_pkg::DELAY_W-1:0] seek_delay_r, sector_delay_r, track_delay_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seek_delay_r   <= fdcr_pkg::SEEK_DELAY_RST;
      sector_delay_r <= fdcr_pkg::SECTOR_DELAY_RST;
      track_delay_r  <= fdcr_pkg::TRACK_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (fdcr_pkg::cfg_idx_t'(cfg_index))
        fdcr_pkg::CFG_SEEK_DELAY:   seek_delay_r   <= cfg_wdata;
        fdcr_pkg::CFG_SECTOR_DELAY: sector_delay_r <= cfg_wdata;
        fdcr_pkg::CFG_TRACK_DELAY:  track_delay_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic           s1_valid_r, out_valid_r;
  logic           s1_memrd_r;
  fdcr_pkg::res_t s1_res_r, out_res_r;
  fdcr_pkg::res_t s1_out;
  logic           s1_adv, acc;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign acc       = in_tvalid && in_tready;

  // ---------------- item fields ----------------
  fdcr_pkg::cmd_t  cmd;
  fdcr_pkg::port_t port_sel;
  logic [7:0]      wdata;
  logic            loaded, wprot, trk0, dchg, idx, present;

  assign cmd      = fdcr_pkg::cmd_t'(in_tuser[2:0]);
  assign port_sel = fdcr_pkg::port_t'(in_tuser[5:3]);
  assign wdata    = in_tdata[7:0];
  assign loaded   = in_tdata[8];
  assign wprot    = in_tdata[9];
  assign trk0     = in_tdata[10];
  assign dchg     = in_tdata[11];
  assign idx      = in_tdata[12];
  assign present  = in_tdata[13];

  // ---------------- controller state ----------------
  logic                         busy_r, busy_nxt;
  logic                         drq_r, drq_nxt;
  logic [2:0]                   drq_cnt_r, drq_cnt_nxt;
  logic                         sized_r, sized_nxt;
  logic [PW-1:0]                pos_r, pos_nxt;
  logic [PW-1:0]                fill_r, fill_nxt;  // bytes [0, fill) hold real data
  logic [fdcr_pkg::DELAY_W-1:0] timer_r, timer_nxt;
  fdcr_pkg::kind_t              kind_r, kind_nxt;
  logic                         irq_pend_r, irq_pend_nxt;
  logic [7:0]                   track_r, track_nxt;
  logic [7:0]                   sector_r, sector_nxt;
  logic [7:0]                   data_r, data_nxt;
  logic [7:0]                   ext_r, ext_nxt;

  fdcr_pkg::res_t res;
  logic           memrd;
  logic           ram_we, ram_re;
  logic [7:0]     ram_wdata, ram_rdata;
  logic           buf_ok, buf_new;
  logic [2:0]     cnt_dec;
  logic [15:0]    timer_dec;

  assign buf_ok    = sized_r && (pos_r < POS_END);
  assign buf_new   = pos_r >= fill_r;
  assign cnt_dec   = drq_cnt_r - 3'd1;
  assign timer_dec = timer_r - 16'd1;

  always_comb begin
    busy_nxt     = busy_r;
    drq_nxt      = drq_r;
    drq_cnt_nxt  = drq_cnt_r;
    sized_nxt    = sized_r;
    pos_nxt      = pos_r;
    fill_nxt     = fill_r;
    timer_nxt    = timer_r;
    kind_nxt     = kind_r;
    irq_pend_nxt = irq_pend_r;
    track_nxt    = track_r;
    sector_nxt   = sector_r;
    data_nxt     = data_r;
    ext_nxt      = ext_r;
    res          = '0;
    memrd        = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_wdata    = 8'h00;

    case (cmd)
      fdcr_pkg::CMD_PORT_WR: begin
        case (port_sel)
          fdcr_pkg::PORT_CMD: begin
            busy_nxt = 1'b1;
            case (wdata[7:4])
              fdcr_pkg::OP_RESTORE: begin
                track_nxt       = 8'h00;
                res.seek_start  = 1'b1;
                res.seek_target = 8'h00;
                timer_nxt       = (seek_delay_r == '0) ? 16'd1 : seek_delay_r;
                kind_nxt        = fdcr_pkg::KIND_SEEK;
              end
              fdcr_pkg::OP_SEEK: begin
                track_nxt       = data_r;
                res.seek_start  = 1'b1;
                res.seek_target = data_r;
                timer_nxt       = (seek_delay_r == '0) ? 16'd1 : seek_delay_r;
                kind_nxt        = fdcr_pkg::KIND_SEEK;
              end
              fdcr_pkg::OP_READ_SECTOR, fdcr_pkg::OP_WRITE_SECTOR: begin
                drq_nxt     = 1'b1;
                drq_cnt_nxt = fdcr_pkg::DRQ_POLLS;
                timer_nxt   = (sector_delay_r == '0) ? 16'd1 : sector_delay_r;
                kind_nxt    = fdcr_pkg::KIND_SECTOR;
              end
              fdcr_pkg::OP_WRITE_TRACK: begin
                sized_nxt   = 1'b1;
                pos_nxt     = '0;
                drq_nxt     = 1'b1;
                drq_cnt_nxt = fdcr_pkg::DRQ_POLLS;
                timer_nxt   = (track_delay_r == '0) ? 16'd1 : track_delay_r;
                kind_nxt    = fdcr_pkg::KIND_TRACK;
              end
              default: busy_nxt = 1'b0;
            endcase
          end
          fdcr_pkg::PORT_TRACK:  track_nxt  = wdata;
          fdcr_pkg::PORT_SECTOR: sector_nxt = wdata;
          fdcr_pkg::PORT_DATA:   data_nxt   = wdata;
          fdcr_pkg::PORT_EXT:    ext_nxt    = wdata;
          default: ;
        endcase
      end
      fdcr_pkg::CMD_PORT_RD: begin
        case (port_sel)
          fdcr_pkg::PORT_CMD: begin
            res.rdata = (busy_r ? fdcr_pkg::ST_BUSY : 8'h00)
                      | (loaded ? 8'h00 : fdcr_pkg::ST_NOT_READY)
                      | (wprot ? fdcr_pkg::ST_WPROT : 8'h00)
                      | (trk0 ? fdcr_pkg::ST_TRK0 : 8'h00);
          end
          fdcr_pkg::PORT_TRACK:  res.rdata = track_r;
          fdcr_pkg::PORT_SECTOR: res.rdata = sector_r;
          fdcr_pkg::PORT_DATA:   res.rdata = data_r;
          fdcr_pkg::PORT_EXT: begin
            res.rdata = (dchg ? fdcr_pkg::EXT_DCHG : 8'h00)
                      | (idx ? fdcr_pkg::EXT_INDEX : 8'h00);
          end
          default: ;
        endcase
      end
      fdcr_pkg::CMD_DRQ_POLL: begin
        if (drq_cnt_r != 3'd0) begin
          drq_cnt_nxt = cnt_dec;
          res.drq_out = (cnt_dec == 3'd0);
        end else begin
          res.drq_out = drq_r;
        end
      end
      fdcr_pkg::CMD_DMA_WR: begin
        if (buf_ok) begin
          ram_we    = 1'b1;
          ram_wdata = wdata;
          pos_nxt   = pos_r + PW'(1);
          if (buf_new) fill_nxt = pos_r + PW'(1);
        end
        drq_nxt = 1'b0;
      end
      fdcr_pkg::CMD_DMA_RD: begin
        if (buf_ok) begin
          pos_nxt = pos_r + PW'(1);
          if (buf_new) begin
            // first touch of this byte: store its reset value
            ram_we   = 1'b1;
            fill_nxt = pos_r + PW'(1);
          end else begin
            ram_re = 1'b1;
            memrd  = 1'b1;
          end
        end
        drq_nxt = 1'b0;
      end
      fdcr_pkg::CMD_DMA_DONE: begin
        drq_nxt       = 1'b0;
        busy_nxt      = 1'b0;
        irq_pend_nxt  = 1'b1;
        res.irq_pulse = 1'b1;
      end
      fdcr_pkg::CMD_TICK: begin
        if (timer_r != '0) begin
          timer_nxt = timer_dec;
          if (timer_dec == 16'd0) begin
            if (kind_r == fdcr_pkg::KIND_TRACK && present && sized_r) begin
              res.format_start = 1'b1;
              res.format_track = track_r;
            end
            if (kind_r == fdcr_pkg::KIND_SECTOR || kind_r == fdcr_pkg::KIND_TRACK) begin
              drq_nxt = 1'b0;
            end
            busy_nxt      = 1'b0;
            irq_pend_nxt  = 1'b1;
            res.irq_pulse = 1'b1;
            kind_nxt      = fdcr_pkg::KIND_NONE;
          end
        end
      end
      default: ;
    endcase

    res.irq_pending  = irq_pend_nxt;
    res.drive_select = ext_nxt[0];
  end

  // ---------------- track buffer ----------------
  fdcr_ram #(
    .WIDTH(8),
    .DEPTH(TRACK_BYTES)
  ) u_track_ram (
    .clk    (clk),
    .wr_en  (acc && ram_we),
    .wr_addr(pos_r[AW-1:0]),
    .wr_data(ram_wdata),
    .rd_en  (acc && ram_re),
    .rd_addr(pos_r[AW-1:0]),
    .rd_data(ram_rdata)
  );

  // ---------------- state registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      drq_r      <= 1'b0;
      drq_cnt_r  <= 3'd0;
      sized_r    <= 1'b0;
      pos_r      <= '0;
      fill_r     <= '0;
      timer_r    <= '0;
      kind_r     <= fdcr_pkg::KIND_NONE;
      irq_pend_r <= 1'b0;
      track_r    <= 8'h00;
      sector_r   <= 8'h01;
      data_r     <= 8'h00;
      ext_r      <= 8'h00;
    end else if (acc) begin
      busy_r     <= busy_nxt;
      drq_r      <= drq_nxt;
      drq_cnt_r  <= drq_cnt_nxt;
      sized_r    <= sized_nxt;
      pos_r      <= pos_nxt;
      fill_r     <= fill_nxt;
      timer_r    <= timer_nxt;
      kind_r     <= kind_nxt;
      irq_pend_r <= irq_pend_nxt;
      track_r    <= track_nxt;
      sector_r   <= sector_nxt;
      data_r     <= data_nxt;
      ext_r      <= ext_nxt;
    end
  end

  // ---------------- result stage and output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) out_valid_r <= s1_valid_r;
      if (acc) s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;
    end
  end

  // DMA read data joins the result as it leaves the result stage
  always_comb begin
    s1_out = s1_res_r;
    if (s1_memrd_r) s1_out.rdata = ram_rdata;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_r   <= res;
      s1_memrd_r <= memrd;
    end
    if (s1_adv) begin
      out_res_r <= s1_out;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

  // ---------------- checks ----------------
  a_pos_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r <= fill_r) && (fill_r <= POS_END))
    else $error("buffer index beyond fill mark");

  a_timer_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (timer_r != '0) |-> (kind_r != fdcr_pkg::KIND_NONE))
    else $error("timer running without a pending command");

  a_irq_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(irq_pend_r))
    else $error("interrupt pending flag dropped");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !acc)
    else $error("item accepted over a held result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("stalled result changed");

endmodule

// ----- rtl/fdcr_ram.sv -----
module fdcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 6250
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
